/* sv/tosa_pkg.sv */
// tosa_pkg: shared codes, defaults and types of the typed operand stack alu
// no dependencies; used by the interfaces, the arithmetic unit and the top level
package tosa_pkg;

	localparam int DEF_STACK_DEPTH = 40;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam int OP_W     = 4;
	localparam int TAG_W    = 3;
	localparam int STATUS_W = 3;
	localparam int PORT_VW  = 32;

	localparam logic [TAG_W-1:0] DIGIT_TAG = 3'd4;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 4'd0,
		OP_DUP    = 4'd1,
		OP_EXCH   = 4'd2,
		OP_PUSH   = 4'd3,
		OP_POP    = 4'd4,
		OP_ADD    = 4'd5,
		OP_SUB    = 4'd6,
		OP_MUL    = 4'd7,
		OP_DIV    = 4'd8,
		OP_D2N    = 4'd9,
		OP_POPDIG = 4'd10,
		OP_UNGET  = 4'd11
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_TYPE      = 3'd3,
		ST_DIVZERO   = 3'd4,
		ST_PB_BUSY   = 3'd5
	} status_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} md_ctl_t;

endpackage

/* sv/tosa_req_if.sv */
// tosa_req_if: request channel carrying one stack operation per item
// depends on tosa_pkg for field widths
interface tosa_req_if
	import tosa_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [TAG_W-1:0]    push_type;
	logic signed [PORT_VW-1:0] push_value;
	logic                pushback_pending;

	modport source (output valid, op, push_type, push_value, pushback_pending, input ready);
	modport sink (input valid, op, push_type, push_value, pushback_pending, output ready);
endinterface

/* sv/tosa_rsp_if.sv */
// tosa_rsp_if: result channel, one item per accepted operation
// depends on tosa_pkg for field widths; DEPTH_W follows the stack depth
interface tosa_rsp_if
	import tosa_pkg::*;
#(
	parameter int DEPTH_W = 6
) ();
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic                      out_valid;
	logic signed [PORT_VW-1:0] out_value;
	logic [DEPTH_W-1:0]        stack_depth;

	modport source (output valid, status, out_valid, out_value, stack_depth, input ready);
	modport sink (input valid, status, out_valid, out_value, stack_depth, output ready);
endinterface

/* sv/tosa_muldiv.sv */
// tosa_muldiv: iterative multiplier and signed truncating divider, one bit a cycle
// depends on tosa_pkg for the control struct
module tosa_muldiv
	import tosa_pkg::*;
#(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  md_ctl_t                ctl,
	input  logic [VALUE_WIDTH-1:0] a,
	input  logic [VALUE_WIDTH-1:0] b,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] result
);
	localparam int VW  = VALUE_WIDTH;
	localparam int CW  = $clog2(VW);

	logic [VW-1:0] x_q, y_q, acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q, div_q, neg_q;
	logic [VW:0]   rem_sh, diff;
	logic [VW-1:0] mag_a, mag_b;

	assign mag_a  = a[VW-1] ? (~a + 1'b1) : a;
	assign mag_b  = b[VW-1] ? (~b + 1'b1) : b;
	assign rem_sh = {acc_q, x_q[VW-1]};
	assign diff   = rem_sh - {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			div_q  <= 1'b0;
			neg_q  <= 1'b0;
			x_q    <= '0;
			y_q    <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VW - 1);
				div_q  <= ctl.is_div;
				neg_q  <= a[VW-1] ^ b[VW-1];
				acc_q  <= '0;
				x_q    <= ctl.is_div ? mag_a : a;
				y_q    <= ctl.is_div ? mag_b : b;
			end else if (busy_q) begin
				if (div_q) begin
					// restoring step, quotient bits shift in behind the dividend
					if (!diff[VW]) begin
						acc_q <= diff[VW-1:0];
						x_q   <= {x_q[VW-2:0], 1'b1};
					end else begin
						acc_q <= rem_sh[VW-1:0];
						x_q   <= {x_q[VW-2:0], 1'b0};
					end
				end else begin
					if (y_q[0])
						acc_q <= acc_q + x_q;
					x_q <= {x_q[VW-2:0], 1'b0};
					y_q <= {1'b0, y_q[VW-1:1]};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = div_q ? (neg_q ? (~x_q + 1'b1) : x_q) : acc_q;
endmodule

/* sv/typed_operand_stack_alu_core.sv */
// Typed operand stack with an arithmetic unit: entries of a type tag and a value live in
// one single-port-read synchronous memory, and each operation is read, modified and
// written back by a small sequencer, one item at a time. Clear, push, pop and unused
// codes go from acceptance straight to the result; dup, pop_digit and unget first read
// the top entry; exchange, add and subtract read two; multiply and divide then wait on
// the one-bit-a-cycle shared unit; digits_to_number reads entries in turn via the read port.
// The memory needs no clearing pass, so an item is taken straight after reset.
module typed_operand_stack_alu_core
	import tosa_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	parameter int DEPTH_W     = $clog2(STACK_DEPTH + 1)
) (
	input  logic       clk,
	input  logic       arst_n,
	tosa_req_if.sink   req,
	tosa_rsp_if.source rsp
);
	localparam int VW = VALUE_WIDTH;
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DW = DEPTH_W;
	localparam int EW = VW + 4;
	localparam logic [VW-1:0] SIGN_BIT = {1'b1, {(VW-1){1'b0}}};

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [VW-1:0]    val;
	} entry_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD2  = 8'b0000_0010,
		S_EXEC = 8'b0000_0100,
		S_WR2  = 8'b0000_1000,
		S_MD   = 8'b0001_0000,
		S_DIG  = 8'b0010_0000,
		S_DFIN = 8'b0100_0000,
		S_RESP = 8'b1000_0000
	} state_t;

	typedef enum logic [2:0] {
		PH_WS  = 3'b001,
		PH_NUM = 3'b010,
		PH_END = 3'b100
	} phase_t;

	entry_t mem [STACK_DEPTH];
	entry_t rdata_q, a_q, wd;
	logic   we, re;
	logic [AW-1:0] wa, ra;

	state_t           state_q;
	op_t              op_q, op_in;
	logic [DW-1:0]    top_q, tm1, tm2, cnt_q, cnt_nx;
	logic [VW-1:0]    pval_in;
	logic             pend_q;
	status_t          status_q;
	logic             oval_q;
	logic [PORT_VW-1:0] ovalue_q;

	logic [VW-1:0] acc_q, acc_next, addsub;
	logic          neg_q, terr_q;
	phase_t        ph_q;
	logic [7:0]    ch;
	logic          is_ws, is_sign, is_dig, tags_ok, more;
	logic [EW-1:0] acc_ext, prod, lim;

	md_ctl_t       md_ctl;
	logic          md_done;
	logic [VW-1:0] md_res;

	assign op_in   = op_t'(req.op);
	assign pval_in = VW'($signed(req.push_value));
	assign tm1     = top_q - DW'(1);
	assign tm2     = top_q - DW'(2);
	assign cnt_nx  = cnt_q + DW'(1);
	assign more    = cnt_nx < top_q;

	// operands: a_q holds the top entry, rdata_q the one below
	assign tags_ok = (a_q.tag == DIGIT_TAG) && (rdata_q.tag == DIGIT_TAG);
	assign addsub  = (op_q == OP_SUB) ? (rdata_q.val - a_q.val) : (rdata_q.val + a_q.val);

	// decimal text scan
	assign ch      = rdata_q.val[7:0];
	assign is_ws   = (ch == 8'h20) || (ch inside {[8'h09:8'h0D]});
	assign is_sign = (ch == 8'h2B) || (ch == 8'h2D);
	assign is_dig  = ch inside {[8'h30:8'h39]};
	assign acc_ext = EW'(acc_q);
	assign prod    = (acc_ext << 3) + (acc_ext << 1) + EW'(4'(ch - 8'h30));
	assign lim     = neg_q ? EW'(SIGN_BIT) : (EW'(SIGN_BIT) - EW'(1));
	assign acc_next = (prod > lim) ? lim[VW-1:0] : prod[VW-1:0];

	assign md_ctl.start  = (state_q == S_EXEC) && tags_ok &&
		((op_q == OP_MUL) || ((op_q == OP_DIV) && (a_q.val != '0)));
	assign md_ctl.is_div = (op_q == OP_DIV);

	tosa_muldiv #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (md_ctl),
		.a      (rdata_q.val),
		.b      (a_q.val),
		.done   (md_done),
		.result (md_res)
	);

	// memory strobes
	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		re = 1'b0;
		ra = '0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (op_in)
						OP_PUSH: begin
							if (top_q != DW'(STACK_DEPTH)) begin
								we = 1'b1;
								wa = top_q[AW-1:0];
								wd = '{tag: req.push_type, val: pval_in};
							end
						end
						OP_DUP, OP_EXCH, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
						OP_POPDIG, OP_UNGET: begin
							re = 1'b1;
							ra = tm1[AW-1:0];
						end
						OP_D2N: begin
							re = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_RD2: begin
				re = 1'b1;
				ra = tm2[AW-1:0];
			end
			S_EXEC: begin
				case (op_q)
					OP_DUP: begin
						we = 1'b1;
						wa = top_q[AW-1:0];
						wd = rdata_q;
					end
					OP_EXCH: begin
						we = 1'b1;
						wa = tm1[AW-1:0];
						wd = rdata_q;
					end
					OP_ADD, OP_SUB: begin
						we = tags_ok;
						wa = tm2[AW-1:0];
						wd = '{tag: DIGIT_TAG, val: addsub};
					end
					default: ;
				endcase
			end
			S_WR2: begin
				we = 1'b1;
				wa = tm2[AW-1:0];
				wd = a_q;
			end
			S_MD: begin
				we = md_done;
				wa = tm2[AW-1:0];
				wd = '{tag: DIGIT_TAG, val: md_res};
			end
			S_DIG: begin
				re = more;
				ra = cnt_nx[AW-1:0];
			end
			S_DFIN: begin
				we = !terr_q;
				wd = '{tag: DIGIT_TAG, val: neg_q ? (~acc_q + 1'b1) : acc_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rdata_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			top_q    <= '0;
			op_q     <= OP_CLEAR;
			pend_q   <= 1'b0;
			status_q <= ST_OK;
			oval_q   <= 1'b0;
			ovalue_q <= '0;
			a_q      <= '0;
			cnt_q    <= '0;
			acc_q    <= '0;
			neg_q    <= 1'b0;
			terr_q   <= 1'b0;
			ph_q     <= PH_WS;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q     <= op_in;
						pend_q   <= req.pushback_pending;
						status_q <= ST_OK;
						oval_q   <= 1'b0;
						ovalue_q <= '0;
						state_q  <= S_RESP;
						case (op_in)
							OP_CLEAR: top_q <= '0;
							OP_DUP: begin
								if (top_q == '0)
									status_q <= ST_UNDERFLOW;
								else if (top_q > DW'(STACK_DEPTH - 2))
									status_q <= ST_OVERFLOW;
								else
									state_q <= S_EXEC;
							end
							OP_EXCH, OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
								if (top_q < DW'(2))
									status_q <= ST_UNDERFLOW;
								else
									state_q <= S_RD2;
							end
							OP_PUSH: begin
								if (top_q == DW'(STACK_DEPTH))
									status_q <= ST_OVERFLOW;
								else
									top_q <= top_q + DW'(1);
							end
							OP_POP: begin
								if (top_q == '0)
									status_q <= ST_UNDERFLOW;
								else
									top_q <= tm1;
							end
							OP_D2N: begin
								cnt_q   <= '0;
								acc_q   <= '0;
								neg_q   <= 1'b0;
								terr_q  <= 1'b0;
								ph_q    <= PH_WS;
								state_q <= (top_q == '0) ? S_DFIN : S_DIG;
							end
							OP_POPDIG, OP_UNGET: begin
								if (top_q == '0)
									status_q <= ST_UNDERFLOW;
								else
									state_q <= S_EXEC;
							end
							default: ;
						endcase
					end
				end
				S_RD2: begin
					a_q     <= rdata_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_RESP;
					case (op_q)
						OP_DUP: top_q <= top_q + DW'(1);
						OP_EXCH: begin
							state_q <= S_WR2;
						end
						OP_POPDIG, OP_UNGET: begin
							top_q <= tm1;
							if (rdata_q.tag != DIGIT_TAG)
								status_q <= ST_TYPE;
							else if ((op_q == OP_UNGET) && pend_q)
								status_q <= ST_PB_BUSY;
							else begin
								oval_q   <= 1'b1;
								ovalue_q <= PORT_VW'($signed(rdata_q.val));
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
							if (!tags_ok)
								status_q <= ST_TYPE;
							else if ((op_q == OP_DIV) && (a_q.val == '0))
								status_q <= ST_DIVZERO;
							else if ((op_q == OP_MUL) || (op_q == OP_DIV))
								state_q <= S_MD;
							else
								top_q <= tm1;
						end
						default: ;
					endcase
				end
				S_WR2: state_q <= S_RESP;
				S_MD: begin
					if (md_done) begin
						top_q   <= tm1;
						state_q <= S_RESP;
					end
				end
				S_DIG: begin
					if (rdata_q.tag != DIGIT_TAG)
						terr_q <= 1'b1;
					case (ph_q)
						PH_WS: begin
							if (is_ws)
								ph_q <= PH_WS;
							else if (is_sign) begin
								neg_q <= (ch == 8'h2D);
								ph_q  <= PH_NUM;
							end else if (is_dig) begin
								acc_q <= acc_next;
								ph_q  <= PH_NUM;
							end else
								ph_q <= PH_END;
						end
						PH_NUM: begin
							if (is_dig)
								acc_q <= acc_next;
							else
								ph_q <= PH_END;
						end
						default: ;
					endcase
					if (more)
						cnt_q <= cnt_nx;
					else
						state_q <= S_DFIN;
				end
				S_DFIN: begin
					if (terr_q)
						status_q <= ST_TYPE;
					else
						top_q <= DW'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = (state_q == S_RESP);
	assign rsp.status      = status_q;
	assign rsp.out_valid   = oval_q;
	assign rsp.out_value   = ovalue_q;
	assign rsp.stack_depth = top_q;
endmodule
